// ----- rtl/erat_pkg.sv -----
// ----------------------------------------------------------------------------
// erat_pkg: shared types and constants
// Configuration layout, queue item format and back-end state encoding for
// the extent run address translator.
// ----------------------------------------------------------------------------
package erat_pkg;

  // field widths
  localparam int unsigned SlotW    = 4;
  localparam int unsigned StartW   = 48;
  localparam int unsigned LenW     = 32;
  localparam int unsigned RecW     = 48;
  localparam int unsigned OffW     = 60;
  localparam int unsigned SecIdxW  = 3;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  // sectors produced per record at most
  localparam int unsigned MaxSectors = 8;
  localparam int unsigned SecCntW    = $clog2(MaxSectors + 1);

  localparam int unsigned MaxRunsDef = 16;
  localparam int unsigned QueueDepth = 2;

  // configuration reset values
  localparam logic [3:0] SectorShiftRst  = 4'd9;
  localparam logic [4:0] ClusterShiftRst = 5'd12;
  localparam logic [3:0] RecordShiftRst  = 4'd10;
  localparam logic [4:0] RunCountRst     = 5'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SECTOR_SHIFT  = 2'd0,
    CFG_CLUSTER_SHIFT = 2'd1,
    CFG_RECORD_SHIFT  = 2'd2,
    CFG_RUN_COUNT     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XLATE = 1'b1
  } op_e;

  typedef struct packed {
    logic [3:0] sector_shift;
    logic [4:0] cluster_shift;
    logic [3:0] record_shift;
    logic [4:0] run_count;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [SlotW-1:0]   slot;
    logic [StartW-1:0]  start;
    logic [LenW-1:0]    len;
    logic [AddrW-1:0]   first_sector;
    logic [SecCntW-1:0] count;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SPLIT,
    ST_WALK,
    ST_HIT,
    ST_EMIT
  } state_e;

endpackage

// ----- rtl/erat_if.sv -----
// ----------------------------------------------------------------------------
// erat_in_if / erat_out_if: item channels
// Valid/ready channels carrying command items in and translation results out.
// ----------------------------------------------------------------------------
interface erat_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [erat_pkg::SlotW-1:0]   run_slot;
  logic [erat_pkg::StartW-1:0]  run_start_cluster;
  logic [erat_pkg::LenW-1:0]    run_cluster_count;
  logic [erat_pkg::RecW-1:0]    rec_num;

  modport source (output valid, cmd, run_slot, run_start_cluster, run_cluster_count,
                  rec_num, input ready);
  modport sink   (input valid, cmd, run_slot, run_start_cluster, run_cluster_count,
                  rec_num, output ready);
endinterface

interface erat_out_if;
  logic                          valid;
  logic                          ready;
  logic [erat_pkg::OffW-1:0]     byte_offset;
  logic [erat_pkg::SecIdxW-1:0]  sector_index;
  logic                          not_found;
  logic                          last;

  modport source (output valid, byte_offset, sector_index, not_found, last,
                  input ready);
  modport sink   (input valid, byte_offset, sector_index, not_found, last,
                  output ready);
endinterface

// ----- rtl/erat_front.sv -----
// ----------------------------------------------------------------------------
// erat_front: item intake and classification
// Registers each accepted item, works out the sector count and first sector
// of translate items, and drops translates whose record holds no sector.
// ----------------------------------------------------------------------------
module erat_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  erat_pkg::cfg_t    cfg_i,
  erat_in_if.sink           in_ch,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output erat_pkg::item_t   push_data_o
);

  logic            fv_q, fv_d;
  erat_pkg::item_t f_q, f_d;
  logic            accept;
  logic            skip;
  logic [3:0]      diff;
  int unsigned     cnt_full;

  assign in_ch.ready = !fv_q || push_ready_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    diff     = cfg_i.record_shift - cfg_i.sector_shift;
    skip     = (erat_pkg::op_e'(in_ch.cmd) == erat_pkg::OP_XLATE) &&
               (cfg_i.record_shift < cfg_i.sector_shift);
    cnt_full = 32'd1 << diff;

    f_d.op           = erat_pkg::op_e'(in_ch.cmd);
    f_d.slot         = in_ch.run_slot;
    f_d.start        = in_ch.run_start_cluster;
    f_d.len          = in_ch.run_cluster_count;
    f_d.first_sector = erat_pkg::AddrW'(in_ch.rec_num) << diff;
    f_d.count        = (cnt_full > erat_pkg::MaxSectors) ?
                       erat_pkg::SecCntW'(erat_pkg::MaxSectors) :
                       erat_pkg::SecCntW'(cnt_full);

    fv_d = fv_q;
    if (accept) begin
      fv_d = !skip;
    end else if (fv_q && push_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q <= f_d;
    end
  end

  assign push_valid_o = fv_q;
  assign push_data_o  = f_q;

endmodule

// ----- rtl/erat_queue.sv -----
// ----------------------------------------------------------------------------
// erat_queue: item queue between front and back
// Short first-in first-out buffer so that either side can stall on its own.
// ----------------------------------------------------------------------------
module erat_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  erat_pkg::item_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output erat_pkg::item_t pop_data_o
);

  localparam int unsigned PtrW = (erat_pkg::QueueDepth > 1) ?
                                 $clog2(erat_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(erat_pkg::QueueDepth + 1);

  erat_pkg::item_t mem_q [erat_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(erat_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(erat_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(erat_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/erat_back.sv -----
// ----------------------------------------------------------------------------
// erat_back: run table and sector translation sequencer
// Holds the run table, and for each sector of a translate item walks the
// runs one per cycle, then forms the physical byte offset.
// ----------------------------------------------------------------------------
module erat_back #(
  parameter int unsigned MAX_RUNS = erat_pkg::MaxRunsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  erat_pkg::cfg_t  cfg_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  erat_pkg::item_t pop_data_i,
  erat_out_if.source      out_ch
);

  localparam int unsigned RunAW   = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned RunCntW = $clog2(MAX_RUNS + 1);
  localparam int unsigned VcnW    = erat_pkg::LenW + RunCntW;
  localparam int unsigned InCW    = 31;
  localparam int unsigned PcW     = erat_pkg::StartW + 1;

  // run table, undefined until loaded
  logic [erat_pkg::StartW-1:0] start_mem [MAX_RUNS];
  logic [erat_pkg::LenW-1:0]   len_mem   [MAX_RUNS];
  logic [erat_pkg::StartW-1:0] start_rd_q;
  logic [erat_pkg::LenW-1:0]   len_rd_q;
  logic                        tbl_we;
  logic [RunAW-1:0]            wr_addr, rd_addr;

  erat_pkg::state_e            state_q, state_d;
  erat_pkg::item_t             ent_q, ent_d;
  logic [erat_pkg::SecCntW-1:0] s_q, s_d;
  logic [erat_pkg::AddrW-1:0]  abs_q, abs_d, vc_q, vc_d;
  logic [InCW-1:0]             inc_q, inc_d;
  logic [RunCntW-1:0]          i_q, i_d, run_n;
  logic [VcnW-1:0]             vcn_q, vcn_d;
  logic [erat_pkg::LenW-1:0]   rel_q, rel_d;
  logic [PcW-1:0]              pc_q, pc_d;
  logic                        nf_q, nf_d;

  logic                        ov_q, ov_d;
  logic [erat_pkg::OffW-1:0]   off_q, off_d;
  logic [erat_pkg::SecIdxW-1:0] sidx_q, sidx_d;
  logic                        onf_q, onf_d, olast_q, olast_d;

  logic [4:0]                  spc;
  logic [erat_pkg::AddrW-1:0]  cl_mask, walk_end;
  logic [erat_pkg::OffW-1:0]   where;
  logic                        out_free, emit_last, run_hit, walk_done;

  assign run_n = (32'(cfg_i.run_count) > MAX_RUNS) ? RunCntW'(MAX_RUNS) :
                                                     RunCntW'(cfg_i.run_count);
  // sectors per cluster saturates at one when clusters are smaller
  assign spc       = (cfg_i.cluster_shift > 5'(cfg_i.sector_shift)) ?
                     cfg_i.cluster_shift - 5'(cfg_i.sector_shift) : '0;
  assign cl_mask   = (erat_pkg::AddrW'(1) << cfg_i.cluster_shift) - erat_pkg::AddrW'(1);
  assign walk_end  = erat_pkg::AddrW'(vcn_q) + erat_pkg::AddrW'(len_rd_q);
  assign walk_done = (i_q == run_n);
  assign run_hit   = (vc_q < walk_end);
  assign where     = (erat_pkg::OffW'(pc_q) << cfg_i.cluster_shift) +
                     erat_pkg::OffW'(inc_q);
  assign out_free  = !ov_q || out_ch.ready;
  assign emit_last = nf_q || ((s_q + erat_pkg::SecCntW'(1)) == ent_q.count);
  assign pop_ready_o = (state_q == erat_pkg::ST_IDLE);
  assign tbl_we    = pop_valid_i && pop_ready_o && (pop_data_i.op == erat_pkg::OP_LOAD) &&
                     (32'(pop_data_i.slot) < MAX_RUNS);
  assign wr_addr   = RunAW'(pop_data_i.slot);
  assign rd_addr   = i_d[RunAW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      erat_pkg::ST_IDLE: begin
        if (pop_valid_i && pop_data_i.op == erat_pkg::OP_XLATE) begin
          state_d = erat_pkg::ST_ADDR;
        end
      end
      erat_pkg::ST_ADDR:  state_d = erat_pkg::ST_SPLIT;
      erat_pkg::ST_SPLIT: state_d = erat_pkg::ST_WALK;
      erat_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = erat_pkg::ST_EMIT;
        end else if (run_hit) begin
          state_d = erat_pkg::ST_HIT;
        end
      end
      erat_pkg::ST_HIT:   state_d = erat_pkg::ST_EMIT;
      erat_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = emit_last ? erat_pkg::ST_IDLE : erat_pkg::ST_ADDR;
        end
      end
      default: state_d = erat_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ent_d   = ent_q;
    s_d     = s_q;
    abs_d   = abs_q;
    vc_d    = vc_q;
    inc_d   = inc_q;
    i_d     = i_q;
    vcn_d   = vcn_q;
    rel_d   = rel_q;
    pc_d    = pc_q;
    nf_d    = nf_q;
    ov_d    = ov_q && !out_ch.ready;
    off_d   = off_q;
    sidx_d  = sidx_q;
    onf_d   = onf_q;
    olast_d = olast_q;
    unique case (state_q)
      erat_pkg::ST_IDLE: begin
        if (pop_valid_i) begin
          ent_d = pop_data_i;
          s_d   = '0;
        end
      end
      erat_pkg::ST_ADDR: begin
        abs_d = ent_q.first_sector + erat_pkg::AddrW'(s_q);
        i_d   = '0;
        vcn_d = '0;
        nf_d  = 1'b0;
      end
      erat_pkg::ST_SPLIT: begin
        vc_d  = abs_q >> spc;
        inc_d = InCW'((abs_q << cfg_i.sector_shift) & cl_mask);
      end
      erat_pkg::ST_WALK: begin
        if (walk_done) begin
          nf_d = 1'b1;
        end else if (run_hit) begin
          // covering run found: offset of the cluster inside it fits the length
          rel_d = erat_pkg::LenW'(vc_q - erat_pkg::AddrW'(vcn_q));
        end else begin
          vcn_d = VcnW'(walk_end);
          i_d   = i_q + RunCntW'(1);
        end
      end
      erat_pkg::ST_HIT: begin
        pc_d = PcW'(start_rd_q) + PcW'(rel_q);
      end
      erat_pkg::ST_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          off_d   = nf_q ? '0 : where;
          sidx_d  = erat_pkg::SecIdxW'(s_q);
          onf_d   = nf_q;
          olast_d = emit_last;
          s_d     = s_q + erat_pkg::SecCntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= erat_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    s_q     <= s_d;
    abs_q   <= abs_d;
    vc_q    <= vc_d;
    inc_q   <= inc_d;
    i_q     <= i_d;
    vcn_q   <= vcn_d;
    rel_q   <= rel_d;
    pc_q    <= pc_d;
    nf_q    <= nf_d;
    off_q   <= off_d;
    sidx_q  <= sidx_d;
    onf_q   <= onf_d;
    olast_q <= olast_d;
  end

  // table write and registered read, address runs one ahead of the walk
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      start_mem[wr_addr] <= pop_data_i.start;
      len_mem[wr_addr]   <= pop_data_i.len;
    end
    start_rd_q <= start_mem[rd_addr];
    len_rd_q   <= len_mem[rd_addr];
  end

  assign out_ch.valid        = ov_q;
  assign out_ch.byte_offset  = off_q;
  assign out_ch.sector_index = sidx_q;
  assign out_ch.not_found    = onf_q;
  assign out_ch.last         = olast_q;

  a_nf_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && onf_q |-> olast_q)
    else $error("not-found result without last");

  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && onf_q |-> off_q == '0)
    else $error("not-found result with nonzero offset");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == erat_pkg::ST_WALK |-> i_q <= run_n)
    else $error("run walk past table end");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == erat_pkg::ST_EMIT && ov_q && !out_ch.ready |=> state_q == erat_pkg::ST_EMIT)
    else $error("result dropped while output stalled");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != erat_pkg::ST_IDLE |-> !pop_ready_o)
    else $error("queue popped while busy");

endmodule

// ----- rtl/extent_run_address_translator_core.sv -----
// ----------------------------------------------------------------------------
// extent_run_address_translator_core: extent run address translator
// Translates record numbers into per-sector physical byte offsets through a
// loadable table of extent runs.
// ----------------------------------------------------------------------------
// Input channel in_ch carries load items (cmd 0: write one run table entry)
// and translate items (cmd 1: record number). Output channel out_ch returns
// one result per sector of a translated record, in order, with last set on
// the final one; a not-found result ends the sequence early. Loads give no
// result. The configuration port writes the shift and run count registers
// one per cycle and must only be used while the block is idle.
// An accepted item is registered by the front end and queued; the back end
// takes one item at a time. A load is written into the run table as it leaves
// the queue. Per sector of a translate, the address and split steps form the
// cluster number and in-cluster offset, the walk reads one table entry per
// cycle until a run holds the cluster or the run count is reached; on a hit
// the hit step forms the physical cluster, and the emit step sends the result.
// Reset clears the configuration to its defaults and empties the queue and
// output register; the run table keeps no reset value. When out_ch stalls
// the result is held, the back end waits, and input is still taken until
// the front register and queue are full.
// ----------------------------------------------------------------------------
module extent_run_address_translator_core #(
  parameter int unsigned MAX_RUNS = erat_pkg::MaxRunsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [erat_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [erat_pkg::CfgDataW-1:0] cfg_data_i,
  erat_in_if.sink                       in_ch,
  erat_out_if.source                    out_ch
);

  erat_pkg::cfg_t  cfg_q, cfg_d;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  erat_pkg::item_t push_data, pop_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (erat_pkg::cfg_idx_e'(cfg_idx_i))
        erat_pkg::CFG_SECTOR_SHIFT:  cfg_d.sector_shift  = cfg_data_i[3:0];
        erat_pkg::CFG_CLUSTER_SHIFT: cfg_d.cluster_shift = cfg_data_i[4:0];
        erat_pkg::CFG_RECORD_SHIFT:  cfg_d.record_shift  = cfg_data_i[3:0];
        erat_pkg::CFG_RUN_COUNT:     cfg_d.run_count     = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sector_shift  <= erat_pkg::SectorShiftRst;
      cfg_q.cluster_shift <= erat_pkg::ClusterShiftRst;
      cfg_q.record_shift  <= erat_pkg::RecordShiftRst;
      cfg_q.run_count     <= erat_pkg::RunCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  erat_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  erat_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  erat_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_ch      (out_ch)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: extent run address translator
// Directed table of loads, translates and register settings, then random
// phases with fresh settings and run tables. Every result is checked field by
// field against a behavioural translation model kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  import erat_pkg::*;

  typedef struct packed {
    logic [OffW-1:0]    byte_offset;
    logic [SecIdxW-1:0] sector_index;
    logic               not_found;
    logic               last;
  } sector_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    op_e               op;
    logic [SlotW-1:0]  slot;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic [RecW-1:0]   rec;
    bit                typed_miss;  // expect one not-found result at sector 0
    cfg_idx_e          idx;
    logic [4:0]        val;
  } stim_row_t;

  localparam logic [StartW-1:0] StartMax = '1;
  localparam logic [LenW-1:0]   LenMax   = '1;
  localparam logic [RecW-1:0]   RecMax   = '1;
  localparam int unsigned       SettleCycles = 64;
  localparam int unsigned       HoldCycles   = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  erat_in_if  in_ch ();
  erat_out_if out_ch ();

  extent_run_address_translator_core i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // model state
  logic [StartW-1:0] run_start[MaxRunsDef];
  logic [LenW-1:0]   run_len[MaxRunsDef];
  cfg_t              xcfg;
  sector_res_t       expected_sectors[$];

  bit drv_typed_miss;
  bit send_idle;
  bit sink_idle;
  bit hold_req;
  int hold_left;
  int stall_left;

  int errors;
  int n_loads;
  int n_xlates;
  int n_results;
  int n_misses;
  int n_cfg;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // expected sector results of one translate, walked the way the block does
  function automatic void predict_sectors(input logic [RecW-1:0] rec);
    logic [63:0] first_sec, abs_sec, vc, in_cl, base, where;
    int unsigned diff, count, spc, nruns;
    bit          hit;
    sector_res_t r;
    if (xcfg.record_shift < xcfg.sector_shift) return;
    diff  = xcfg.record_shift - xcfg.sector_shift;
    count = 1 << diff;
    if (count > MaxSectors) count = MaxSectors;
    spc   = (xcfg.cluster_shift > xcfg.sector_shift) ?
            xcfg.cluster_shift - xcfg.sector_shift : 0;
    nruns = (xcfg.run_count > MaxRunsDef) ? MaxRunsDef : xcfg.run_count;
    first_sec = 64'(rec) << diff;
    for (int unsigned s = 0; s < count; s++) begin
      abs_sec = first_sec + 64'(s);
      vc      = abs_sec >> spc;
      in_cl   = (abs_sec << xcfg.sector_shift) & ((64'd1 << xcfg.cluster_shift) - 64'd1);
      hit     = 1'b0;
      base    = '0;
      where   = '0;
      for (int unsigned i = 0; i < nruns && !hit; i++) begin
        if (vc < base + 64'(run_len[i])) begin
          where = ((64'(run_start[i]) + (vc - base)) << xcfg.cluster_shift) + in_cl;
          hit   = 1'b1;
        end else begin
          base += 64'(run_len[i]);
        end
      end
      r.byte_offset  = hit ? where[OffW-1:0] : '0;
      r.sector_index = s[SecIdxW-1:0];
      r.not_found    = !hit;
      r.last         = !hit || (s + 1 == count);
      expected_sectors = {expected_sectors, r};
      if (!hit) return;
    end
  endfunction

  // item acceptance and result checking, both at the rising edge
  always @(posedge clk_i) begin : monitor
    sector_res_t want;
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      if (in_ch.cmd == OP_LOAD) begin
        n_loads++;
        run_start[in_ch.run_slot] = in_ch.run_start_cluster;
        run_len[in_ch.run_slot]   = in_ch.run_cluster_count;
      end else begin
        n_xlates++;
        if (drv_typed_miss) begin
          want = '{byte_offset: '0, sector_index: '0, not_found: 1'b1, last: 1'b1};
          expected_sectors = {expected_sectors, want};
        end else begin
          predict_sectors(in_ch.rec_num);
        end
      end
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.not_found) n_misses++;
      if (expected_sectors.size() == 0) begin
        $error("unexpected result: byte_offset %h sector_index %0d",
               out_ch.byte_offset, out_ch.sector_index);
        errors++;
      end else begin
        want = expected_sectors.pop_front();
        if (out_ch.byte_offset !== want.byte_offset) begin
          $error("byte_offset: expected %h, got %h", want.byte_offset, out_ch.byte_offset);
          errors++;
        end
        if (out_ch.sector_index !== want.sector_index) begin
          $error("sector_index: expected %0d, got %0d",
                 want.sector_index, out_ch.sector_index);
          errors++;
        end
        if (out_ch.not_found !== want.not_found) begin
          $error("not_found: expected %b, got %b", want.not_found, out_ch.not_found);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        if (sink_idle) stall_left = gap_len();
      end
    end
  end

  task automatic send_item(input op_e op, input logic [SlotW-1:0] slot,
                           input logic [StartW-1:0] start, input logic [LenW-1:0] len,
                           input logic [RecW-1:0] rec, input bit typed_miss);
    int gap;
    gap = send_idle ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid             = 1'b1;
    in_ch.cmd               = op;
    in_ch.run_slot          = slot;
    in_ch.run_start_cluster = start;
    in_ch.run_cluster_count = len;
    in_ch.rec_num           = rec;
    drv_typed_miss          = typed_miss;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // drop valid, wait for every result, then let any result-less item finish
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_sectors.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CFG_SECTOR_SHIFT:  xcfg.sector_shift  = val[3:0];
      CFG_CLUSTER_SHIFT: xcfg.cluster_shift = val;
      CFG_RECORD_SHIFT:  xcfg.record_shift  = val[3:0];
      CFG_RUN_COUNT:     xcfg.run_count     = val;
      default: ;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic stim_row_t item_row(input op_e op, input logic [SlotW-1:0] slot,
                                         input logic [StartW-1:0] start,
                                         input logic [LenW-1:0] len,
                                         input logic [RecW-1:0] rec, input bit typed_miss);
    stim_row_t r;
    r = '{kind: ROW_ITEM, op: op, slot: slot, start: start, len: len, rec: rec,
          typed_miss: typed_miss, idx: CFG_SECTOR_SHIFT, val: '0};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_idx_e idx, input logic [4:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, op: OP_LOAD, slot: '0, start: '0, len: '0, rec: '0,
          typed_miss: 1'b0, idx: idx, val: val};
    return r;
  endfunction

  initial begin : stimulus
    stim_row_t         rows[$];
    bit                dirty;
    logic [63:0]       rnd, total, span, vc;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   len;
    logic [RecW-1:0]   rec;
    int unsigned       sel, diff, spc, nruns;
    logic [4:0]        sec_v, clu_v, rec_v, rc_v;

    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_SECTOR_SHIFT;
    cfg_data_i              = '0;
    in_ch.valid             = 1'b0;
    in_ch.cmd               = OP_LOAD;
    in_ch.run_slot          = '0;
    in_ch.run_start_cluster = '0;
    in_ch.run_cluster_count = '0;
    in_ch.rec_num           = '0;
    drv_typed_miss          = 1'b0;
    send_idle               = 1'b1;
    sink_idle               = 1'b1;
    hold_req                = 1'b0;
    hold_left               = 0;
    stall_left              = 0;
    xcfg.sector_shift       = SectorShiftRst;
    xcfg.cluster_shift      = ClusterShiftRst;
    xcfg.record_shift       = RecordShiftRst;
    xcfg.run_count          = RunCountRst;
    for (int i = 0; i < MaxRunsDef; i++) begin
      run_start[i] = '0;
      run_len[i]   = '0;
    end

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table after reset: nothing can be found
    rows = {rows, item_row(OP_XLATE, 4'd9, StartMax, LenMax, '0, 1'b1)};
    rows = {rows, item_row(OP_XLATE, 4'd0, '0, '0, RecMax, 1'b1)};
    // fill every slot before any walk can reach it
    rows = {rows, item_row(OP_LOAD, 4'd0, 48'd100, 32'd4, RecMax, 1'b0)};
    rows = {rows, item_row(OP_LOAD, 4'd1, '0, '0, '0, 1'b0)};  // zero-length run
    rows = {rows, item_row(OP_LOAD, 4'd2, StartMax, 32'd2, '0, 1'b0)};
    rows = {rows, item_row(OP_LOAD, 4'd3, 48'd5000, LenMax, '0, 1'b0)};
    for (int i = 4; i < MaxRunsDef; i++)
      rows = {rows, item_row(OP_LOAD, SlotW'(i), StartW'(i * 4096 + 7), LenW'(i), '0, 1'b0)};
    rows = {rows, cfg_row(CFG_RUN_COUNT, 5'd16)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd0, 1'b0)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd16, 1'b0)};  // skips empty run
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd17, 1'b0)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, RecMax, 1'b0)};
    // run count above the table size
    rows = {rows, cfg_row(CFG_RUN_COUNT, 5'd31)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd3000, 1'b0)};
    // record smaller than a sector: no result at all
    rows = {rows, cfg_row(CFG_SECTOR_SHIFT, 5'd12)};
    rows = {rows, cfg_row(CFG_RECORD_SHIFT, 5'd9)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd5, 1'b0)};
    // cluster smaller than a sector
    rows = {rows, cfg_row(CFG_RECORD_SHIFT, 5'd12)};
    rows = {rows, cfg_row(CFG_CLUSTER_SHIFT, 5'd9)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd7, 1'b0)};
    // sector count capped
    rows = {rows, cfg_row(CFG_SECTOR_SHIFT, 5'd9)};
    rows = {rows, cfg_row(CFG_RECORD_SHIFT, 5'd13)};
    rows = {rows, cfg_row(CFG_CLUSTER_SHIFT, 5'd16)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd1, 1'b0)};
    // miss part-way through a record
    rows = {rows, cfg_row(CFG_RECORD_SHIFT, 5'd12)};
    rows = {rows, cfg_row(CFG_CLUSTER_SHIFT, 5'd9)};
    rows = {rows, cfg_row(CFG_RUN_COUNT, 5'd1)};
    rows = {rows, item_row(OP_XLATE, '0, '0, '0, 48'd0, 1'b0)};

    dirty = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (dirty) settle();
        dirty = 1'b0;
        cfg_write(rows[i].idx, rows[i].val);
      end else begin
        send_item(rows[i].op, rows[i].slot, rows[i].start, rows[i].len, rows[i].rec,
                  rows[i].typed_miss);
        dirty = 1'b1;
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case (ph)
        0: begin sec_v = 5'd9;  clu_v = 5'd9;  rec_v = 5'd9;  rc_v = 5'd16; end
        1: begin sec_v = 5'd12; clu_v = 5'd16; rec_v = 5'd12; rc_v = 5'd16; end
        default: begin
          sec_v = 5'($urandom_range(9, 12));
          clu_v = 5'($urandom_range(9, 16));
          rec_v = 5'($urandom_range(9, 12));
          sel   = $urandom_range(0, 9);
          rc_v  = (sel == 0) ? 5'd0 : (sel == 1) ? 5'($urandom_range(17, 31))
                                                 : 5'($urandom_range(1, 16));
        end
      endcase
      cfg_write(CFG_SECTOR_SHIFT, sec_v);
      cfg_write(CFG_CLUSTER_SHIFT, clu_v);
      cfg_write(CFG_RECORD_SHIFT, rec_v);
      cfg_write(CFG_RUN_COUNT, rc_v);

      send_idle = !(ph == 2 || ph == 3);
      sink_idle = (ph != 2);
      if (ph == 3) hold_req = 1'b1;  // block fills while results are held back

      for (int n = 0; n < 28; n++) begin
        rnd = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
          0:       start = '0;
          1:       start = StartMax;
          2, 3:    start = StartW'($urandom_range(0, 1 << 20));
          default: start = rnd[StartW-1:0];
        endcase
        case ($urandom_range(0, 9))
          0:       len = '0;
          1:       len = LenMax;
          2:       len = $urandom();
          default: len = $urandom_range(1, 64);
        endcase
        if ($urandom_range(0, 99) < 15) begin
          send_item(OP_LOAD, SlotW'($urandom_range(0, MaxRunsDef - 1)), start, len,
                    rnd[63:16], 1'b0);
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 5) begin
            rec = (sel < 2) ? '0 : RecMax;
          end else if (sel < 20 || xcfg.record_shift < xcfg.sector_shift) begin
            rec = rnd[RecW-1:0];
          end else begin
            // aim at (or just past) the clusters the table covers
            diff  = xcfg.record_shift - xcfg.sector_shift;
            spc   = (xcfg.cluster_shift > xcfg.sector_shift) ?
                    xcfg.cluster_shift - xcfg.sector_shift : 0;
            nruns = (xcfg.run_count > MaxRunsDef) ? MaxRunsDef : xcfg.run_count;
            total = '0;
            for (int i = 0; i < nruns; i++) total += 64'(run_len[i]);
            span = total + (total >> 3) + 64'd2;
            vc   = rnd % span;
            rec  = RecW'((vc << spc) >> diff);
          end
          send_item(OP_XLATE, start[SlotW-1:0], start, len, rec, 1'b0);
        end
      end
    end

    settle();
    $display("translated %0d records and loaded %0d runs over %0d register writes",
             n_xlates, n_loads, n_cfg);
    $display("checked %0d sector results, %0d of them not found", n_results, n_misses);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
